// ----- rtl/sfs_pkg.sv -----
// Shared types, codes and constants of the sprite frame stepper.
package sfs_pkg;

    // Sheet and timing limits
    localparam int GRID_MAX  = 16;
    localparam int FRAME_MAX = 256;
    localparam int TIME_BITS = 16;

    // Channel widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 88;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Shared divider widths
    localparam int DVD_W     = 18;
    localparam int DSR_W     = 16;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_DURATION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE      = 3'd4;

    // Play modes
    localparam logic [1:0] MODE_ONCE      = 2'd0;
    localparam logic [1:0] MODE_LOOP      = 2'd1;
    localparam logic [1:0] MODE_PING_PONG = 2'd2;
    localparam logic [1:0] MODE_RANDOM    = 2'd3;

    // Item kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TIME_WAIT,
        ST_WRAP_WAIT,
        ST_PER_WAIT,
        ST_BOUNCE,
        ST_CELL_GO,
        ST_CELL_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DSR_W-1:0] remainder;
    } div_rsp_t;

    // Q1.16 cell span: floor(65536 / count) for a clamped count of 1 to 16
    function automatic logic [16:0] cell_span(input logic [4:0] count);
        logic [16:0] span;
        case (count)
            5'd1:    span = 17'd65536;
            5'd2:    span = 17'd32768;
            5'd3:    span = 17'd21845;
            5'd4:    span = 17'd16384;
            5'd5:    span = 17'd13107;
            5'd6:    span = 17'd10922;
            5'd7:    span = 17'd9362;
            5'd8:    span = 17'd8192;
            5'd9:    span = 17'd7281;
            5'd10:   span = 17'd6553;
            5'd11:   span = 17'd5957;
            5'd12:   span = 17'd5461;
            5'd13:   span = 17'd5041;
            5'd14:   span = 17'd4681;
            5'd15:   span = 17'd4369;
            default: span = 17'd4096;
        endcase
        return span;
    endfunction

endpackage

// ----- rtl/sfs_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module sfs_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  sfs_pkg::div_req_t req,
    output sfs_pkg::div_rsp_t rsp
);
    import sfs_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DVD_W - 1);

    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DVD_W-1:0]     quo_next;
    logic [DSR_W-1:0]     rem_reg;
    logic [DSR_W-1:0]     rem_next;
    logic [DSR_W-1:0]     dsr_reg;
    logic [DSR_W:0]       trial;
    logic [DSR_W:0]       diff;
    logic                 fits;

    // Shift in the next dividend bit, subtract where the divisor fits
    always_comb begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_LAST;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end else if (run_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !run_reg)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !run_reg)
        else $error("divider done while still running");

    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg && cnt_reg == '0 && !req.start) |=> done_reg)
        else $error("divider missed its done pulse");

endmodule

// ----- rtl/sprite_frame_stepper_top.sv -----
// Sprite-sheet frame stepper: top level with sequencer, state and result register.
//
// Each input beat is either a tick (add elapsed time, step the frame by whole
// frame durations under the play mode) or a restart (clear timer and finished
// flag, go to frame 0, or to the supplied start frame saturated to the last
// frame in random-start mode). Every beat returns one result beat with the
// frame, its grid column and row, the Q0.16 cell origin and the Q1.16 cell
// size. All divisions run through one shared 18-step restoring divider. A
// restart, or a tick in once mode after the run has finished, runs only the
// cell divide. A tick runs the time divide and then the cell divide; when a
// frame boundary is crossed, loop modes add a wrap divide and ping-pong mode
// a period divide and then its bounce steps, at most two plus the period minus
// one (the period is 2*(frames-1), or 1 for a single frame). The sequencer
// waits while the previous result still sits in the output register.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register while the next beat is taken.
// Write configuration only while the block is idle.
module sprite_frame_stepper_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfs_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sfs_pkg::S_TDATA_W-1:0]   s_tdata,   // elapsed[15:0], start_frame[23:16]
    input  logic                            s_tuser,   // kind: 0 tick, 1 restart
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // frame[7:0], cell_col[11:8], cell_row[15:12], u_origin[31:16],
    // v_origin[47:32], cell_width[64:48], cell_height[81:65], finished[82],
    // zero[87:83]
    output logic [sfs_pkg::M_TDATA_W-1:0]   m_tdata
);
    import sfs_pkg::*;

    // Configuration registers
    logic [4:0]           grid_rows_reg;
    logic [4:0]           grid_cols_reg;
    logic [8:0]           frame_total_reg;
    logic [TIME_BITS-1:0] frame_duration_reg;
    logic [1:0]           play_mode_reg;

    // Animation state
    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] accum_reg, accum_next;
    logic [7:0]           frame_reg, frame_next;
    logic                 done_reg, done_next;
    logic                 down_reg, down_next;
    logic [1:0]           lead_reg, lead_next;
    logic [9:0]           count_reg, count_next;
    logic [3:0]           col_reg, col_next;
    logic [7:0]           row_reg, row_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Derived sheet geometry
    logic [4:0]           rows_c, cols_c;
    logic [9:0]           cells, n_a, n_b;
    logic [8:0]           n_w;
    logic [7:0]           n_m1;
    logic [9:0]           period;
    logic [TIME_BITS-1:0] dur_eff;
    logic [16:0]          cell_w, cell_h;
    logic [20:0]          u_prod;
    logic [24:0]          v_prod;

    // Step helpers
    logic                 s_accept;
    logic [16:0]          sum_w;
    logic [16:0]          steps_w;
    logic [7:0]           room_w;
    logic [1:0]           lead_w;
    logic [7:0]           start_w;
    logic [10:0]          bn_try, bn_mid, bn_out;
    logic                 bn_dir_mid, bn_dir_out;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    sfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Clamp the grid to 1..GRID_MAX and the frame count to 1..min(cells, FRAME_MAX)
    always_comb begin
        if (grid_rows_reg == '0)                rows_c = 5'd1;
        else if (grid_rows_reg > 5'(GRID_MAX))  rows_c = 5'(GRID_MAX);
        else                                    rows_c = grid_rows_reg;
        if (grid_cols_reg == '0)                cols_c = 5'd1;
        else if (grid_cols_reg > 5'(GRID_MAX))  cols_c = 5'(GRID_MAX);
        else                                    cols_c = grid_cols_reg;
        cells   = 10'(rows_c) * 10'(cols_c);
        n_a     = (10'(frame_total_reg) > cells) ? cells : 10'(frame_total_reg);
        n_b     = (n_a > 10'(FRAME_MAX)) ? 10'(FRAME_MAX) : n_a;
        n_w     = (n_b == '0) ? 9'd1 : n_b[8:0];
        n_m1    = 8'(n_w - 9'd1);
        period  = (n_w > 9'd1) ? {n_w - 9'd1, 1'b0} : 10'd1;
        dur_eff = (frame_duration_reg == '0) ? TIME_BITS'(1) : frame_duration_reg;
        cell_w  = cell_span(cols_c);
        cell_h  = cell_span(rows_c);
    end

    // One ping-pong step: bounce at the top end first, then at the bottom end
    always_comb begin
        bn_try     = {3'b000, frame_reg} + (down_reg ? 11'h7FF : 11'h001);
        bn_mid     = bn_try;
        bn_dir_mid = down_reg;
        if (!bn_try[10] && (bn_try >= {2'b00, n_w})) begin
            bn_mid     = {2'b00, n_w} - 11'd2;
            bn_dir_mid = 1'b1;
        end
        bn_out     = bn_mid;
        bn_dir_out = bn_dir_mid;
        if (bn_mid[10]) begin
            bn_out     = (n_w > 9'd1) ? 11'd1 : 11'd0;
            bn_dir_out = 1'b0;
        end
    end

    assign s_accept = s_tvalid && s_tready;
    assign sum_w    = 17'(accum_reg) + 17'(s_tdata[15:0]);
    assign steps_w  = div_rsp.quotient[16:0];
    assign room_w   = n_m1 - frame_reg;
    assign lead_w   = (steps_w >= 17'd2) ? 2'd2 : steps_w[1:0];
    assign start_w  = (s_tdata[23:16] > n_m1) ? n_m1 : s_tdata[23:16];
    assign u_prod   = 21'(col_reg) * 21'(cell_w);
    assign v_prod   = 25'(row_reg) * 25'(cell_h);

    // Sequencer: next state, state updates and divider launches
    always_comb begin
        state_next    = state_reg;
        accum_next    = accum_reg;
        frame_next    = frame_reg;
        done_next     = done_reg;
        down_next     = down_reg;
        lead_next     = lead_reg;
        count_next    = count_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        div_req       = '{start: 1'b0, dividend: '0, divisor: '0};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == KIND_RESTART) begin
                        accum_next = '0;
                        done_next  = 1'b0;
                        frame_next = (play_mode_reg == MODE_RANDOM) ? start_w : 8'd0;
                        state_next = ST_CELL_GO;
                    end else if (done_reg && play_mode_reg == MODE_ONCE) begin
                        // Finished once-mode run: leave everything as is
                        state_next = ST_CELL_GO;
                    end else begin
                        div_req    = '{start: 1'b1, dividend: DVD_W'(sum_w),
                                       divisor: DSR_W'(dur_eff)};
                        state_next = ST_TIME_WAIT;
                    end
                end
            end

            ST_TIME_WAIT: begin
                if (div_rsp.done) begin
                    accum_next = TIME_BITS'(div_rsp.remainder);
                    state_next = ST_CELL_GO;
                    if (steps_w != '0) begin
                        case (play_mode_reg) inside
                            MODE_ONCE: begin
                                if (frame_reg >= n_m1) begin
                                    done_next = 1'b1;
                                end else if (steps_w > 17'(room_w)) begin
                                    frame_next = n_m1;
                                    done_next  = 1'b1;
                                end else begin
                                    frame_next = frame_reg + steps_w[7:0];
                                end
                            end
                            MODE_PING_PONG: begin
                                // Take up to two steps plainly, fold the rest by the period
                                lead_next  = lead_w;
                                div_req    = '{start: 1'b1,
                                               dividend: DVD_W'(steps_w - 17'(lead_w)),
                                               divisor: DSR_W'(period)};
                                state_next = ST_PER_WAIT;
                            end
                            MODE_LOOP, MODE_RANDOM: begin
                                div_req    = '{start: 1'b1,
                                               dividend: DVD_W'(frame_reg) + DVD_W'(steps_w),
                                               divisor: DSR_W'(n_w)};
                                state_next = ST_WRAP_WAIT;
                            end
                        endcase
                    end
                end
            end

            ST_WRAP_WAIT: begin
                if (div_rsp.done) begin
                    frame_next = div_rsp.remainder[7:0];
                    state_next = ST_CELL_GO;
                end
            end

            ST_PER_WAIT: begin
                if (div_rsp.done) begin
                    count_next = 10'(lead_reg) + div_rsp.remainder[9:0];
                    state_next = ST_BOUNCE;
                end
            end

            ST_BOUNCE: begin
                if (count_reg == '0) begin
                    state_next = ST_CELL_GO;
                end else begin
                    frame_next = bn_out[7:0];
                    down_next  = bn_dir_out;
                    count_next = count_reg - 10'd1;
                end
            end

            ST_CELL_GO: begin
                div_req    = '{start: 1'b1, dividend: DVD_W'(frame_reg),
                               divisor: DSR_W'(cols_c)};
                state_next = ST_CELL_WAIT;
            end

            ST_CELL_WAIT: begin
                if (div_rsp.done) begin
                    col_next   = div_rsp.remainder[3:0];
                    row_next   = div_rsp.quotient[7:0];
                    state_next = ST_OUT;
                end
            end

            ST_OUT: begin
                // Hold the result until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b00000, done_reg, cell_h, cell_w,
                                     v_prod[15:0], u_prod[15:0],
                                     row_reg[3:0], col_reg, frame_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            accum_reg          <= '0;
            frame_reg          <= '0;
            done_reg           <= 1'b0;
            down_reg           <= 1'b0;
            lead_reg           <= '0;
            count_reg          <= '0;
            m_tvalid_reg       <= 1'b0;
            grid_rows_reg      <= 5'd1;
            grid_cols_reg      <= 5'd1;
            frame_total_reg    <= 9'd1;
            frame_duration_reg <= TIME_BITS'(1);
            play_mode_reg      <= MODE_ONCE;
        end else begin
            state_reg    <= state_next;
            accum_reg    <= accum_next;
            frame_reg    <= frame_next;
            done_reg     <= done_next;
            down_reg     <= down_next;
            lead_reg     <= lead_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_GRID_ROWS:      grid_rows_reg      <= cfg_wdata[4:0];
                    REG_GRID_COLS:      grid_cols_reg      <= cfg_wdata[4:0];
                    REG_FRAME_TOTAL:    frame_total_reg    <= cfg_wdata[8:0];
                    REG_FRAME_DURATION: frame_duration_reg <= cfg_wdata[TIME_BITS-1:0];
                    REG_PLAY_MODE:      play_mode_reg      <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == KIND_RESTART) |=> (!done_reg && accum_reg == '0))
        else $error("restart did not clear timer and finished flag");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("accepted a beat while the previous one is in work");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_TIME_WAIT || state_reg == ST_WRAP_WAIT ||
                          state_reg == ST_PER_WAIT  || state_reg == ST_CELL_WAIT))
        else $error("divider result arrived with no waiting state");

endmodule
